/* hw/rtl/lru_keyed_cache_macros.svh */
// ----------------------------------------------------------------------------
// lru_keyed_cache assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_CACHE_MACROS_SVH
`define LRU_KEYED_CACHE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LKC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LKC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define LKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/lkc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lkc_pkg;

   localparam int ENTRIES    = 128;
   localparam int KEY_BITS   = 32;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int VALUE_BITS = 64;
   localparam int CAP_BITS   = 8;
   localparam int MODE_BITS  = 2;
   localparam int OUT_CNT_BITS = 8;

   typedef logic [IDX_BITS-1:0]     idx_type;
   typedef logic [CNT_BITS-1:0]     cnt_type;
   typedef logic [KEY_BITS-1:0]     key_type;
   typedef logic [VALUE_BITS-1:0]   value_type;
   typedef logic [CAP_BITS-1:0]     cap_type;
   typedef logic [MODE_BITS-1:0]    mode_type;
   typedef logic [OUT_CNT_BITS-1:0] out_cnt_type;

   localparam mode_type MODE_GET   = 2'd0;
   localparam mode_type MODE_QUERY = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;

   localparam cap_type CAP_RESET = 8'd128;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic decide;
      logic update_step;
      logic commit;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic need_pass;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/lkc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lkc_datapath.sv */
`timescale 1ns / 1ps
`include "lru_keyed_cache_macros.svh"
// ----------------------------------------------------------------------------
// lkc_datapath
// Key/value/rank memories, present bits, scan and rank-update passes,
// capacity register and the output beat register.
// ----------------------------------------------------------------------------
module lkc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  lkc_pkg::cmd_type       cmd,
   output lkc_pkg::status_type    status,
   input  lkc_pkg::mode_type      req_mode,
   input  logic [31:0]            req_key,
   input  logic                   req_fill_valid,
   input  lkc_pkg::value_type     req_fill_value,
   input  logic                   csr_wr_en,
   input  lkc_pkg::cap_type       csr_wr_data,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic                   rsp_hit,
   output logic                   rsp_value_valid,
   output lkc_pkg::value_type     rsp_value,
   output logic                   rsp_evicted,
   output logic [31:0]            rsp_evicted_key,
   output lkc_pkg::out_cnt_type   rsp_count
);

   // captured request
   lkc_pkg::mode_type  mode_ff, mode_in;
   lkc_pkg::key_type   key_ff, key_in;
   logic               fill_valid_ff, fill_valid_in;
   lkc_pkg::value_type fill_ff, fill_in;

   // pass sequencing
   lkc_pkg::cnt_type   idx_ff, idx_in;
   logic               rd_vld_ff, rd_vld_in;
   lkc_pkg::idx_type   rd_idx_ff, rd_idx_in;

   // scan results
   logic               hit_found_ff, hit_found_in;
   lkc_pkg::idx_type   hit_slot_ff, hit_slot_in;
   lkc_pkg::idx_type   hit_rank_ff, hit_rank_in;
   logic               old_found_ff, old_found_in;
   lkc_pkg::idx_type   old_slot_ff, old_slot_in;
   lkc_pkg::key_type   old_key_ff, old_key_in;
   logic               free_found_ff, free_found_in;
   lkc_pkg::idx_type   free_slot_ff, free_slot_in;

   // decided actions
   logic               act_hit_ff, act_hit_in;
   logic               act_fill_ff, act_fill_in;
   logic               act_evict_ff, act_evict_in;
   lkc_pkg::idx_type   ins_slot_ff, ins_slot_in;
   lkc_pkg::idx_type   excl_slot_ff, excl_slot_in;
   lkc_pkg::idx_type   thr_ff, thr_in;

   // cache state
   logic [lkc_pkg::ENTRIES-1:0] present_ff, present_in;
   lkc_pkg::cnt_type   occ_ff, occ_in;
   lkc_pkg::cap_type   cap_ff, cap_in;

   // output beat
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_vv_ff, rsp_vv_in;
   lkc_pkg::value_type   rsp_value_ff, rsp_value_in;
   logic                 rsp_ev_ff, rsp_ev_in;
   lkc_pkg::key_type     rsp_evk_ff, rsp_evk_in;
   lkc_pkg::out_cnt_type rsp_count_ff, rsp_count_in;

   // memory ports
   lkc_pkg::key_type   key_rd;
   lkc_pkg::idx_type   rank_rd;
   lkc_pkg::value_type value_rd;
   logic               rank_wr_en;
   lkc_pkg::idx_type   rank_wr_addr;
   lkc_pkg::idx_type   rank_wr_data;

   logic               step;
   logic               issue;
   logic               rd_present;
   lkc_pkg::cnt_type   eff_cap;
   logic               is_get;
   logic               dec_hit;
   logic               dec_fill;
   logic               dec_evict;
   lkc_pkg::idx_type   dec_ins;
   logic               dec_rank;

   assign step       = cmd.scan_step | cmd.update_step;
   assign issue      = step && (idx_ff != lkc_pkg::cnt_type'(lkc_pkg::ENTRIES));
   assign rd_present = present_ff[rd_idx_ff];

   // capacity 0 behaves as 1, anything above the array size as the array size
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lkc_pkg::cnt_type'(1);
      end else if (int'(cap_ff) > lkc_pkg::ENTRIES) begin
         eff_cap = lkc_pkg::cnt_type'(lkc_pkg::ENTRIES);
      end else begin
         eff_cap = lkc_pkg::cnt_type'(cap_ff);
      end
   end

   assign is_get    = (mode_ff == lkc_pkg::MODE_GET);
   assign dec_hit   = is_get && hit_found_ff;
   assign dec_fill  = is_get && !hit_found_ff && fill_valid_ff;
   assign dec_evict = dec_fill && (occ_ff >= eff_cap) && (occ_ff != '0);
   assign dec_ins   = (dec_evict && (!free_found_ff || (old_slot_ff < free_slot_ff)))
                      ? old_slot_ff : free_slot_ff;

   assign status.pass_done = (idx_ff == lkc_pkg::cnt_type'(lkc_pkg::ENTRIES)) && !rd_vld_ff;
   assign status.need_pass = dec_hit || dec_evict;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // rank decrement for entries newer than the one leaving its place
   assign dec_rank = cmd.update_step && rd_vld_ff && rd_present &&
                     (rd_idx_ff != excl_slot_ff) && (rank_rd > thr_ff);

   always_comb begin
      rank_wr_en   = 1'b0;
      rank_wr_addr = rd_idx_ff;
      rank_wr_data = rank_rd - lkc_pkg::idx_type'(1);
      if (dec_rank) begin
         rank_wr_en = 1'b1;
      end else if (cmd.commit && act_hit_ff) begin
         rank_wr_en   = 1'b1;
         rank_wr_addr = hit_slot_ff;
         rank_wr_data = lkc_pkg::idx_type'(occ_ff - lkc_pkg::cnt_type'(1));
      end else if (cmd.commit && act_fill_ff) begin
         rank_wr_en   = 1'b1;
         rank_wr_addr = ins_slot_ff;
         rank_wr_data = act_evict_ff ? lkc_pkg::idx_type'(occ_ff - lkc_pkg::cnt_type'(1))
                                     : lkc_pkg::idx_type'(occ_ff);
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      fill_valid_in = fill_valid_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      rd_vld_in     = issue;
      rd_idx_in     = lkc_pkg::idx_type'(idx_ff);
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      old_found_in  = old_found_ff;
      old_slot_in   = old_slot_ff;
      old_key_in    = old_key_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      act_hit_in    = act_hit_ff;
      act_fill_in   = act_fill_ff;
      act_evict_in  = act_evict_ff;
      ins_slot_in   = ins_slot_ff;
      excl_slot_in  = excl_slot_ff;
      thr_in        = thr_ff;
      present_in    = present_ff;
      occ_in        = occ_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_vv_in     = rsp_vv_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evk_in    = rsp_evk_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      if (cmd.capture) begin
         mode_in       = req_mode;
         key_in        = req_key[lkc_pkg::KEY_BITS-1:0];
         fill_valid_in = req_fill_valid;
         fill_in       = req_fill_value;
         idx_in        = '0;
         hit_found_in  = 1'b0;
         old_found_in  = 1'b0;
         free_found_in = 1'b0;
      end

      if (issue) begin
         idx_in = idx_ff + lkc_pkg::cnt_type'(1);
      end

      if (cmd.scan_step && rd_vld_ff) begin
         if (rd_present && (key_rd == key_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_slot_in  = rd_idx_ff;
            hit_rank_in  = rank_rd;
         end
         // ranks of present entries are dense from 0, so rank 0 is the oldest
         if (rd_present && (rank_rd == '0)) begin
            old_found_in = 1'b1;
            old_slot_in  = rd_idx_ff;
            old_key_in   = key_rd;
         end
         if (!rd_present && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = rd_idx_ff;
         end
      end

      if (cmd.decide) begin
         idx_in       = '0;
         act_hit_in   = dec_hit;
         act_fill_in  = dec_fill;
         act_evict_in = dec_evict;
         ins_slot_in  = dec_ins;
         excl_slot_in = dec_hit ? hit_slot_ff : old_slot_ff;
         thr_in       = dec_hit ? hit_rank_ff : '0;
         if (mode_ff == lkc_pkg::MODE_CLEAR) begin
            present_in = '0;
            occ_in     = '0;
         end
      end

      if (cmd.commit && act_fill_ff) begin
         if (act_evict_ff) begin
            present_in[old_slot_ff] = 1'b0;
         end else begin
            occ_in = occ_ff + lkc_pkg::cnt_type'(1);
         end
         present_in[ins_slot_ff] = 1'b1;
      end

      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_found_ff &&
                        ((mode_ff == lkc_pkg::MODE_GET) || (mode_ff == lkc_pkg::MODE_QUERY));
         rsp_vv_in    = act_hit_ff || act_fill_ff;
         rsp_value_in = act_hit_ff ? value_rd : (act_fill_ff ? fill_ff : '0);
         rsp_ev_in    = act_evict_ff;
         rsp_evk_in   = act_evict_ff ? old_key_ff : '0;
         rsp_count_in = lkc_pkg::out_cnt_type'(occ_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         present_ff   <= '0;
         occ_ff       <= '0;
         cap_ff       <= lkc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
         act_hit_ff   <= 1'b0;
         act_fill_ff  <= 1'b0;
         act_evict_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         present_ff   <= present_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         act_hit_ff   <= act_hit_in;
         act_fill_ff  <= act_fill_in;
         act_evict_ff <= act_evict_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      fill_valid_ff <= fill_valid_in;
      fill_ff       <= fill_in;
      rd_idx_ff     <= rd_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      old_found_ff  <= old_found_in;
      old_slot_ff   <= old_slot_in;
      old_key_ff    <= old_key_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      ins_slot_ff   <= ins_slot_in;
      excl_slot_ff  <= excl_slot_in;
      thr_ff        <= thr_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_vv_ff     <= rsp_vv_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evk_ff    <= rsp_evk_in;
      rsp_count_ff  <= rsp_count_in;
   end

   lkc_ram #(
      .WIDTH (lkc_pkg::KEY_BITS),
      .DEPTH (lkc_pkg::ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && act_fill_ff),
      .wr_addr (ins_slot_ff),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (lkc_pkg::idx_type'(idx_ff)),
      .rd_data (key_rd)
   );

   lkc_ram #(
      .WIDTH (lkc_pkg::VALUE_BITS),
      .DEPTH (lkc_pkg::ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && act_fill_ff),
      .wr_addr (ins_slot_ff),
      .wr_data (fill_ff),
      .rd_en   (cmd.decide),
      .rd_addr (hit_slot_ff),
      .rd_data (value_rd)
   );

   lkc_ram #(
      .WIDTH (lkc_pkg::IDX_BITS),
      .DEPTH (lkc_pkg::ENTRIES)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_en   (issue),
      .rd_addr (lkc_pkg::idx_type'(idx_ff)),
      .rd_data (rank_rd)
   );

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_value_valid = rsp_vv_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = 32'(rsp_evk_ff);
   assign rsp_count       = rsp_count_ff;

   `LKC_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= lkc_pkg::cnt_type'(lkc_pkg::ENTRIES), "occupancy above array size")
   `LKC_ASSERT_IMPLY(a_evict_victim, clock, reset, cmd.commit && act_evict_ff, old_found_ff && (occ_ff != '0), "eviction without an oldest entry")
   `LKC_ASSERT_IMPLY(a_insert_free, clock, reset, cmd.commit && act_fill_ff, !present_ff[ins_slot_ff] || (act_evict_ff && (ins_slot_ff == old_slot_ff)), "insert into occupied slot")
   `LKC_ASSERT_NEXT(a_clear_empty, clock, reset, cmd.decide && (mode_ff == lkc_pkg::MODE_CLEAR), (occ_ff == '0) && (present_ff == '0), "clear left entries behind")

endmodule

/* hw/rtl/lkc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_ctrl
// Sequencer: accept, tag scan, decide, rank update pass, commit, deliver.
// ----------------------------------------------------------------------------
module lkc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lkc_pkg::status_type status,
   output lkc_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_COMMIT = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.pass_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.need_pass ? ST_UPDATE : ST_COMMIT;
         end
         ST_UPDATE: begin
            cmd.update_step = 1'b1;
            if (status.pass_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the beat
            cmd.deliver = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

/* hw/rtl/lru_keyed_cache.sv */
`timescale 1ns / 1ps
// Query, clear and plain miss or fill requests run one scan pass before rsp_tvalid;
//   a hit or an eviction adds a rank update pass over all entries.
// A new request is accepted only after the previous one is delivered; the passes
//   walk the key/rank memories one slot per cycle, the update pass over the same port.
// A finished beat waits in the output register while the next request runs.
// Reset: synchronous, active high; cache empty, capacity 128, no clearing pass.
// ----------------------------------------------------------------------------
// lru_keyed_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_keyed_cache (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,   // key_tag[31:0], fill_value[95:32]
   input  logic [2:0]    req_tuser,   // mode[1:0], fill_valid[2]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // result_value[63:0], evicted_key[95:64],
                                      // entry_count[103:96]
   output logic [2:0]    rsp_tuser,   // hit[0], value_valid[1], evicted[2]
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_wr_data  // capacity
);

   lkc_pkg::cmd_type     cmd;
   lkc_pkg::status_type  status;
   logic                 rsp_hit;
   logic                 rsp_value_valid;
   lkc_pkg::value_type   rsp_value;
   logic                 rsp_evicted;
   logic [31:0]          rsp_evicted_key;
   lkc_pkg::out_cnt_type rsp_count;

   lkc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lkc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_tuser[1:0]),
      .req_key         (req_tdata[31:0]),
      .req_fill_valid  (req_tuser[2]),
      .req_fill_value  (req_tdata[95:32]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_hit         (rsp_hit),
      .rsp_value_valid (rsp_value_valid),
      .rsp_value       (rsp_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .rsp_count       (rsp_count)
   );

   assign rsp_tdata = {rsp_count, rsp_evicted_key, rsp_value};
   assign rsp_tuser = {rsp_evicted, rsp_value_valid, rsp_hit};

endmodule
